@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true while out of reset.
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("assertion failed: forbidden condition");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/shs_pkg.sv @@
// Shared types and constants of the SHA-256 stream hasher.
package shs_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [3:0] LEN_HI_WORD  = 4'd14;
    localparam logic [3:0] LAST_WORD    = 4'd15;
    localparam logic [5:0] LAST_ROUND   = 6'd63;
    localparam logic [63:0] BYTE_BITS   = 64'd8;

    // One 32-bit message word on its way from front to back.
    typedef struct packed {
        logic [31:0] word;
        logic        final_word;  // last word of the last block of a message
    } word_item_t;

    localparam logic [31:0] INIT_WORDS [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

@@ hw/rtl/sha256_stream_hasher_top.sv @@
// Top level of the SHA-256 stream hasher: front end, word queue, compression engine.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata message_byte, tuser has_byte, tlast end
//  m_      | out | m_tvalid/m_tready  | tdata digest_w0..digest_w7 (w0 lowest)
//
// Bytes go in at one item per cycle until the four-word queue fills; an end item then
// holds s_tready low while the pad and length words go out, longer if the queue fills.
// Per block the engine runs 64 rounds and a fold step, then loads 16 words, of which only
// four wait queued; the rest come through the queue as the front end pushes them.
// Reset (aresetn low, synchronous) restores the initial hash values and empties the queue.
// A digest waits in the output register; the next one holds the engine until m_tready.
`include "assert_macros.svh"

module sha256_stream_hasher_top #(
    parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] message_byte
    input  logic [0:0]   s_tuser,   // [0] has_byte
    input  logic         s_tlast,   // end_of_message
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // [31:0] digest_w0 ... [255:224] digest_w7
);

    // Word stream from the front end into the queue.
    logic                push;
    shs_pkg::word_item_t push_item;
    logic                q_full;
    // Queue head toward the compression engine.
    logic                pop;
    logic                q_valid;
    shs_pkg::word_item_t q_item;

    shs_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_tvalid),
        .s_ready        (s_tready),
        .has_byte       (s_tuser[0]),
        .message_byte   (s_tdata),
        .end_of_message (s_tlast),
        .push           (push),
        .push_item      (push_item),
        .q_full         (q_full)
    );

    shs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .pop_item  (q_item)
    );

    // Engine: 16-word schedule window, rounds, chaining words, digest register.
    shs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata)
    );

    // The front end never writes into a full queue.
    `ASSERT_NEVER(a_no_push_full, aclk, aresetn, push && q_full)
    // The engine never takes a word from an empty queue.
    `ASSERT_NEVER(a_no_pop_empty, aclk, aresetn, pop && !q_valid)
    // An end item sends the front end into padding, so the next item waits.
    `ASSERT_NEXT(a_end_stalls, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule

@@ hw/rtl/shs_front.sv @@
// Front end: packs message bytes into words and generates the padding words.
module shs_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               has_byte,
    input  logic [7:0]         message_byte,
    input  logic               end_of_message,
    output logic               push,
    output shs_pkg::word_item_t push_item,
    input  logic               q_full
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PAD    = 5'b00010,
        ST_ZERO   = 5'b00100,
        ST_LEN_HI = 5'b01000,
        ST_LEN_LO = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [5:0]   fill_reg, fill_next;
    logic [31:0]  acc_reg, acc_next;
    logic [63:0]  len_reg, len_next;
    logic [3:0]   widx_inc;
    logic [31:0]  pad_word;
    logic         accept;

    assign s_ready  = (state_reg == ST_IDLE) && !q_full;
    assign accept   = s_valid && s_ready;
    assign widx_inc = fill_reg[5:2] + 4'd1;

    // Bytes already held in the partial word, then the pad byte, then zeros.
    always_comb begin
        case (fill_reg[1:0])
            2'd0:    pad_word = {shs_pkg::PAD_BYTE, 24'h0};
            2'd1:    pad_word = {acc_reg[31:24], shs_pkg::PAD_BYTE, 16'h0};
            2'd2:    pad_word = {acc_reg[31:16], shs_pkg::PAD_BYTE, 8'h0};
            default: pad_word = {acc_reg[31:8], shs_pkg::PAD_BYTE};
        endcase
    end

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        push       = 1'b0;
        push_item  = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (has_byte) begin
                        acc_next[{~fill_reg[1:0], 3'b111} -: 8] = message_byte;
                        fill_next = fill_reg + 6'd1;
                        len_next  = len_reg + shs_pkg::BYTE_BITS;
                        if (fill_reg[1:0] == 2'd3) begin
                            push           = 1'b1;
                            push_item.word = {acc_reg[31:8], message_byte};
                        end
                    end
                    if (end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD, ST_ZERO: begin
                if (!q_full) begin
                    push           = 1'b1;
                    push_item.word = (state_reg == ST_PAD) ? pad_word : 32'h0;
                    fill_next      = {widx_inc, 2'b00};
                    state_next     = (widx_inc == shs_pkg::LEN_HI_WORD) ? ST_LEN_HI : ST_ZERO;
                end
            end
            ST_LEN_HI: begin
                if (!q_full) begin
                    push           = 1'b1;
                    push_item.word = len_reg[63:32];
                    state_next     = ST_LEN_LO;
                end
            end
            ST_LEN_LO: begin
                if (!q_full) begin
                    push                 = 1'b1;
                    push_item.word       = len_reg[31:0];
                    push_item.final_word = 1'b1;
                    fill_next            = '0;
                    len_next             = '0;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
        end
        acc_reg <= acc_next;
    end

endmodule

@@ hw/rtl/shs_queue.sv @@
// Short word queue between the front end and the compression engine.
module shs_queue #(
    parameter int DEPTH = shs_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  shs_pkg::word_item_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                valid,
    output shs_pkg::word_item_t pop_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    shs_pkg::word_item_t entries_reg [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/shs_core.sv @@
// Compression engine: 16-word schedule window, one round per cycle, digest register.
module shs_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  shs_pkg::word_item_t q_item,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [255:0]        m_data
);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_ROUND = 3'b010,
        ST_FOLD  = 3'b100
    } core_state_t;

    function automatic logic [31:0] ror(input logic [31:0] v, input int amt);
        ror = (v >> amt) | (v << (32 - amt));
    endfunction

    core_state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        final_reg, final_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] w_reg     [0:15];
    logic [31:0] w_next    [0:15];
    logic [31:0] work_reg  [0:7];
    logic [31:0] work_next [0:7];
    logic [31:0] chain_reg [0:7];
    logic [31:0] chain_next[0:7];
    logic [31:0] out_reg   [0:7];
    logic [31:0] out_next  [0:7];
    logic [31:0] fold_sum  [0:7];
    logic [31:0] sched_word, t1, t2, big0, big1, choose, major;
    logic        emit_ok;

    // Next schedule word and round terms.
    always_comb begin
        sched_word = (ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10))
                   + w_reg[9]
                   + (ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3))
                   + w_reg[0];
        big1   = ror(work_reg[4], 6) ^ ror(work_reg[4], 11) ^ ror(work_reg[4], 25);
        choose = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        t1     = work_reg[7] + big1 + choose + shs_pkg::ROUND_K[cnt_reg] + w_reg[0];
        big0   = ror(work_reg[0], 2) ^ ror(work_reg[0], 13) ^ ror(work_reg[0], 22);
        major  = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
        t2     = big0 + major;
        for (int i = 0; i < 8; i++) begin
            fold_sum[i] = chain_reg[i] + work_reg[i];
        end
    end

    assign pop     = (state_reg == ST_LOAD) && q_valid;
    assign emit_ok = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            m_data[32*i +: 32] = out_reg[i];
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg && !m_ready;
        w_next         = w_reg;
        work_next      = work_reg;
        chain_next     = chain_reg;
        out_next       = out_reg;
        case (state_reg)
            ST_LOAD: begin
                if (q_valid) begin
                    for (int i = 0; i < 15; i++) begin
                        w_next[i] = w_reg[i+1];
                    end
                    w_next[15] = q_item.word;
                    cnt_next   = cnt_reg + 6'd1;
                    if (cnt_reg[3:0] == shs_pkg::LAST_WORD) begin
                        cnt_next   = '0;
                        final_next = q_item.final_word;
                        work_next  = chain_reg;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                for (int i = 0; i < 15; i++) begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[15] = sched_word;
                for (int i = 1; i < 8; i++) begin
                    work_next[i] = work_reg[i-1];
                end
                work_next[4] = work_reg[3] + t1;
                work_next[0] = t1 + t2;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == shs_pkg::LAST_ROUND) begin
                    cnt_next   = '0;
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (!final_reg) begin
                    chain_next = fold_sum;
                    state_next = ST_LOAD;
                end else if (emit_ok) begin
                    out_next       = fold_sum;
                    out_valid_next = 1'b1;
                    chain_next     = shs_pkg::INIT_WORDS;
                    state_next     = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= shs_pkg::INIT_WORDS;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
        end
        w_reg    <= w_next;
        work_reg <= work_next;
        out_reg  <= out_next;
    end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the SHA-256 stream hasher: random byte streams, digest scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  DRAIN_CYCLES  = 400;    // two compressions plus pad, with margin
    localparam int  HOLD_CYCLES   = 3000;   // long receiver hold-off
    localparam int  RANDOM_ITEMS  = 900;
    localparam int  MIN_MESSAGES  = 16;
    localparam logic [7:0] PAD_MARK = 8'h80;

    // One input item: a byte (or none) and the end flag.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] msg_byte;
        logic       end_msg;
    } hash_item_t;

    // Digest words, w0 in the lowest slot, as on m_tdata.
    typedef logic [7:0][31:0] digest_t;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // DUT ports; every input starts at a known value.
    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;   // [7:0] message_byte
    logic [0:0]   s_tuser  = 1'b0;    // [0] has_byte
    logic         s_tlast  = 1'b0;    // end_of_message
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;            // [31:0] digest_w0 ... [255:224] digest_w7

    // Predictor state: chaining words, block buffer, fill level, bits of full blocks.
    logic [31:0] hash_words [8];
    logic [7:0]  block_bytes [64];
    int unsigned block_fill;
    logic [63:0] folded_bits;

    hash_item_t  send_q [$];          // items waiting for the driver
    digest_t     digest_q [$];        // digests predicted, not yet seen

    int items_queued    = 0;          // items that carry a byte or an end flag
    int idles_queued    = 0;
    int messages_queued = 0;
    int digests_seen    = 0;
    int err_count       = 0;
    int cycle_count     = 0;

    // sender pacing
    int         burst_left = 1;
    int         gap_left   = 0;
    hash_item_t drive_item;

    // receiver pacing
    int  hold_left  = 0;
    bit  held_once  = 1'b0;
    int  ready_mode = 0;
    int  mode_left  = 0;

    hash_item_t taken_item;
    digest_t    got_digest;
    digest_t    want_digest;

    sha256_stream_hasher_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Digest predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] rotr(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void hash_restart();
        for (int i = 0; i < 8; i++) hash_words[i] = SHA_IV[i];
        block_fill  = 0;
        folded_bits = 64'd0;
    endfunction

    // 64-round compression of block_bytes into hash_words.
    function automatic void fold_block();
        logic [31:0] w [64];
        logic [31:0] r [8];
        logic [31:0] s0, s1, t1, t2, ch, maj;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) r[i] = hash_words[i];
        for (int i = 0; i < 64; i++) begin
            s1  = rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25);
            ch  = (r[4] & r[5]) ^ (~r[4] & r[6]);
            t1  = r[7] + s1 + ch + SHA_K[i] + w[i];
            s0  = rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22);
            maj = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
            t2  = s0 + maj;
            r[7] = r[6]; r[6] = r[5]; r[5] = r[4];
            r[4] = r[3] + t1;
            r[3] = r[2]; r[2] = r[1]; r[1] = r[0];
            r[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_words[i] = hash_words[i] + r[i];
    endfunction

    // Absorb one accepted item; on the end flag, pad, finish and queue the digest.
    function automatic void hash_take(hash_item_t it);
        logic [63:0] total;
        int          pos;
        digest_t     d;
        if (it.has_byte) begin
            block_bytes[block_fill] = it.msg_byte;
            block_fill++;
            if (block_fill == 64) begin
                fold_block();
                folded_bits = folded_bits + 64'd512;
                block_fill  = 0;
            end
        end
        if (!it.end_msg) return;
        total = folded_bits + 64'(block_fill) * 64'd8;
        pos = block_fill;
        block_bytes[pos] = PAD_MARK;
        pos++;
        // no room for the length: pad out this block and use another
        if (pos > 56) begin
            while (pos < 64) begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            fold_block();
            pos = 0;
        end
        while (pos < 56) begin
            block_bytes[pos] = 8'h00;
            pos++;
        end
        for (int j = 0; j < 8; j++) block_bytes[63-j] = total[8*j +: 8];
        fold_block();
        for (int j = 0; j < 8; j++) d[j] = hash_words[j];
        digest_q.push_back(d);
        hash_restart();
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_item(bit has, logic [7:0] b, bit last);
        hash_item_t it;
        it.has_byte = has;
        it.msg_byte = b;
        it.end_msg  = last;
        send_q.push_back(it);
        if (has || last) items_queued++;
        else idles_queued++;
        if (last) messages_queued++;
    endfunction

    // Random message with idle noise; ends on its last byte or on a bare end item.
    function automatic void queue_message(int len, bit end_on_byte);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(9, 0) == 0) queue_item(1'b0, 8'($urandom_range(255, 0)), 1'b0);
            queue_item(1'b1, 8'($urandom_range(255, 0)), end_on_byte && (n == len - 1));
        end
        if (!end_on_byte || len == 0) queue_item(1'b0, 8'($urandom_range(255, 0)), 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of items with random gaps, fed from send_q
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0 || send_q.size() == 0) begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                drive_item = send_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drive_item.msg_byte;
                s_tuser  <= drive_item.has_byte;
                s_tlast  <= drive_item.end_msg;
                if (burst_left <= 1) begin
                    // now and then a long stretch at full rate
                    if ($urandom_range(3, 0) == 0) begin
                        burst_left = $urandom_range(300, 100);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(24, 1);
                        gap_left   = $urandom_range(10, 1);
                    end
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern in modes, plus one long hold-off that backs
    // the block up into its input while the sender keeps offering items.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!held_once && digests_seen >= 8) begin
            held_once <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(2, 0);
                mode_left  <= $urandom_range(300, 40);
            end else begin
                mode_left  <= mode_left - 1;
            end
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(1, 0));
                default: m_tready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted item, check every accepted digest
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            taken_item.has_byte = s_tuser[0];
            taken_item.msg_byte = s_tdata;
            taken_item.end_msg  = s_tlast;
            hash_take(taken_item);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got_digest = m_tdata;
            if (digest_q.size() == 0) begin
                $error("digest with none expected: %h", m_tdata);
                err_count++;
            end else begin
                want_digest = digest_q.pop_front();
                for (int i = 0; i < 8; i++) begin
                    if (got_digest[i] !== want_digest[i]) begin
                        $error("digest_w%0d: expected %08h, actual %08h",
                               i, want_digest[i], got_digest[i]);
                        err_count++;
                    end
                end
            end
            digests_seen <= digests_seen + 1;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int len;
        hash_restart();
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;

        // directed: empty message, idle items, "abc", byte with end,
        // byte then bare end, two empty messages back to back
        queue_item(1'b0, 8'hff, 1'b1);
        queue_item(1'b0, 8'hff, 1'b0);
        queue_item(1'b0, 8'h00, 1'b0);
        queue_item(1'b1, 8'h61, 1'b0);
        queue_item(1'b1, 8'h62, 1'b0);
        queue_item(1'b1, 8'h63, 1'b1);
        queue_item(1'b1, 8'h00, 1'b1);
        queue_item(1'b1, 8'hff, 1'b0);
        queue_item(1'b0, 8'h55, 1'b1);
        queue_item(1'b0, 8'haa, 1'b1);
        queue_item(1'b0, 8'h00, 1'b1);

        // random messages; lengths cluster around the pad and block boundaries
        while (items_queued + idles_queued < RANDOM_ITEMS ||
               messages_queued < MIN_MESSAGES) begin
            case ($urandom_range(19, 0))
                0, 1, 2: len = $urandom_range(3, 0);
                3, 4, 5: len = $urandom_range(58, 52);
                6, 7, 8: len = $urandom_range(66, 60);
                9:       len = $urandom_range(130, 110);
                10:      len = $urandom_range(260, 150);
                default: len = $urandom_range(24, 1);
            endcase
            queue_message(len, 1'($urandom_range(1, 0)));
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (send_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d message items and %0d idle items in %0d messages",
                 items_queued, idles_queued, messages_queued);
        $display("%0d digests compared, receiver hold-off of %0d cycles included",
                 digests_seen, HOLD_CYCLES);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
